### rtl/srit_pkg.sv
// ----------------------------------------------------------------------------
// srit_pkg
// Widths, payload types and helpers for the segment/rectangle edge test.
// ----------------------------------------------------------------------------
package srit_pkg;

   localparam int COORD_BITS  = 16;
   localparam int EXTENT_BITS = 15;

   localparam int MAX_BITS = (COORD_BITS > EXTENT_BITS) ? COORD_BITS : EXTENT_BITS;
   localparam int OFS_W    = MAX_BITS + 2;
   localparam int PROD_W   = 2 * OFS_W;
   localparam int SUM_W    = PROD_W + 1;

   localparam int REQ_BITS = 6 * COORD_BITS + 2 * EXTENT_BITS;
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_W    = 8;

   localparam int NUM_EDGES   = 4;
   localparam int EDGE_LEFT   = 0;
   localparam int EDGE_RIGHT  = 1;
   localparam int EDGE_TOP    = 2;
   localparam int EDGE_BOTTOM = 3;

   typedef struct packed {
      logic signed [OFS_W-1:0] dx;
      logic signed [OFS_W-1:0] dy;
      logic signed [OFS_W-1:0] ofs_l;
      logic signed [OFS_W-1:0] ofs_r;
      logic signed [OFS_W-1:0] ofs_b;
      logic signed [OFS_W-1:0] ofs_t;
      logic signed [OFS_W-1:0] wid;
      logic signed [OFS_W-1:0] hgt;
   } diff_type;

   typedef struct packed {
      logic signed [PROD_W-1:0] dx_h;
      logic signed [PROD_W-1:0] dy_w;
      logic signed [PROD_W-1:0] l_h;
      logic signed [PROD_W-1:0] r_h;
      logic signed [PROD_W-1:0] b_w;
      logic signed [PROD_W-1:0] t_w;
      logic signed [PROD_W-1:0] dy_l;
      logic signed [PROD_W-1:0] dy_r;
      logic signed [PROD_W-1:0] dx_b;
      logic signed [PROD_W-1:0] dx_t;
   } prod_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] det;
      logic signed [SUM_W-1:0] tn;
      logic signed [SUM_W-1:0] un;
   } edge_type;

   typedef edge_type [NUM_EDGES-1:0] edges_type;

   function automatic logic signed [SUM_W-1:0] ext_prod(input logic signed [PROD_W-1:0] p);
      ext_prod = {p[PROD_W-1], p};
   endfunction

endpackage

### rtl/srit_diff.sv
// ----------------------------------------------------------------------------
// srit_diff
// Stage 1: unpack the request and form segment deltas and edge offsets.
// ----------------------------------------------------------------------------
module srit_diff (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [srit_pkg::REQ_W-1:0]    in_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output srit_pkg::diff_type            out_data
);

   localparam int C = srit_pkg::COORD_BITS;
   localparam int E = srit_pkg::EXTENT_BITS;
   localparam int W = srit_pkg::OFS_W;

   logic signed [C-1:0] x1, y1, x2, y2, lft, bot;
   logic        [E-1:0] wid, hgt;
   logic signed [W-1:0] x1_e, y1_e, x2_e, y2_e, lft_e, bot_e, wid_e, hgt_e;

   logic               valid_ff;
   srit_pkg::diff_type data_ff;
   srit_pkg::diff_type data_in;

   assign x1  = in_data[C-1:0];
   assign y1  = in_data[2*C-1:C];
   assign x2  = in_data[3*C-1:2*C];
   assign y2  = in_data[4*C-1:3*C];
   assign lft = in_data[5*C-1:4*C];
   assign bot = in_data[6*C-1:5*C];
   assign wid = in_data[6*C+E-1:6*C];
   assign hgt = in_data[6*C+2*E-1:6*C+E];

   assign x1_e  = W'(x1);
   assign y1_e  = W'(y1);
   assign x2_e  = W'(x2);
   assign y2_e  = W'(y2);
   assign lft_e = W'(lft);
   assign bot_e = W'(bot);
   assign wid_e = signed'({{(W-E){1'b0}}, wid});
   assign hgt_e = signed'({{(W-E){1'b0}}, hgt});

   always_comb begin
      data_in.dx    = x1_e - x2_e;
      data_in.dy    = y1_e - y2_e;
      data_in.ofs_l = x1_e - lft_e;
      data_in.ofs_r = x1_e - lft_e - wid_e;
      data_in.ofs_b = y1_e - bot_e;
      data_in.ofs_t = y1_e - bot_e - hgt_e;
      data_in.wid   = wid_e;
      data_in.hgt   = hgt_e;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### rtl/srit_mult.sv
// ----------------------------------------------------------------------------
// srit_mult
// Stage 2: cross products of deltas, offsets and extents.
// ----------------------------------------------------------------------------
module srit_mult (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  srit_pkg::diff_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output srit_pkg::prod_type out_data
);

   logic               valid_ff;
   srit_pkg::prod_type data_ff;
   srit_pkg::prod_type data_in;

   always_comb begin
      data_in.dx_h = in_data.dx * in_data.hgt;
      data_in.dy_w = in_data.dy * in_data.wid;
      data_in.l_h  = in_data.ofs_l * in_data.hgt;
      data_in.r_h  = in_data.ofs_r * in_data.hgt;
      data_in.b_w  = in_data.ofs_b * in_data.wid;
      data_in.t_w  = in_data.ofs_t * in_data.wid;
      data_in.dy_l = in_data.dy * in_data.ofs_l;
      data_in.dy_r = in_data.dy * in_data.ofs_r;
      data_in.dx_b = in_data.dx * in_data.ofs_b;
      data_in.dx_t = in_data.dx * in_data.ofs_t;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### rtl/srit_comb.sv
// ----------------------------------------------------------------------------
// srit_comb
// Stage 3: determinant and both parameter numerators for each edge.
// ----------------------------------------------------------------------------
module srit_comb (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  srit_pkg::prod_type  in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output srit_pkg::edges_type out_data
);

   logic                valid_ff;
   srit_pkg::edges_type data_ff;
   srit_pkg::edges_type data_in;

   always_comb begin
      data_in[srit_pkg::EDGE_LEFT].det    = -srit_pkg::ext_prod(in_data.dx_h);
      data_in[srit_pkg::EDGE_LEFT].tn     = -srit_pkg::ext_prod(in_data.l_h);
      data_in[srit_pkg::EDGE_LEFT].un     = srit_pkg::ext_prod(in_data.dy_l)
                                          - srit_pkg::ext_prod(in_data.dx_b);
      data_in[srit_pkg::EDGE_RIGHT].det   = -srit_pkg::ext_prod(in_data.dx_h);
      data_in[srit_pkg::EDGE_RIGHT].tn    = -srit_pkg::ext_prod(in_data.r_h);
      data_in[srit_pkg::EDGE_RIGHT].un    = srit_pkg::ext_prod(in_data.dy_r)
                                          - srit_pkg::ext_prod(in_data.dx_b);
      data_in[srit_pkg::EDGE_TOP].det     = srit_pkg::ext_prod(in_data.dy_w);
      data_in[srit_pkg::EDGE_TOP].tn      = srit_pkg::ext_prod(in_data.t_w);
      data_in[srit_pkg::EDGE_TOP].un      = srit_pkg::ext_prod(in_data.dy_l)
                                          - srit_pkg::ext_prod(in_data.dx_t);
      data_in[srit_pkg::EDGE_BOTTOM].det  = srit_pkg::ext_prod(in_data.dy_w);
      data_in[srit_pkg::EDGE_BOTTOM].tn   = srit_pkg::ext_prod(in_data.b_w);
      data_in[srit_pkg::EDGE_BOTTOM].un   = srit_pkg::ext_prod(in_data.dy_l)
                                          - srit_pkg::ext_prod(in_data.dx_b);
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### rtl/srit_cmp.sv
// ----------------------------------------------------------------------------
// srit_cmp
// Stage 4: sign-aware range checks per edge, merged into the hit flag.
// ----------------------------------------------------------------------------
module srit_cmp (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  srit_pkg::edges_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output logic                out_hit
);

   localparam int S = srit_pkg::SUM_W;

   logic [srit_pkg::NUM_EDGES-1:0] edge_hit;
   logic                           valid_ff;
   logic                           hit_ff;
   logic                           hit_in;

   always_comb begin
      for (int i = 0; i < srit_pkg::NUM_EDGES; i++) begin
         if (in_data[i].det == S'(0)) begin
            edge_hit[i] = 1'b0;
         end else if (!in_data[i].det[S-1]) begin
            edge_hit[i] = (in_data[i].tn >= 0) && (in_data[i].tn <= in_data[i].det)
                       && (in_data[i].un >= 0) && (in_data[i].un <= in_data[i].det);
         end else begin
            edge_hit[i] = (in_data[i].tn <= 0) && (in_data[i].tn >= in_data[i].det)
                       && (in_data[i].un <= 0) && (in_data[i].un >= in_data[i].det);
         end
      end
      hit_in = |edge_hit;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         hit_ff <= hit_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_hit   = hit_ff;

endmodule

### rtl/segment_rect_intersection_test_top.sv
// ----------------------------------------------------------------------------
// segment_rect_intersection_test_top
// Segment versus axis-aligned rectangle edge crossing test, four stages.
// Each of diff, mult, comb and cmp holds one item, registered in that order.
// Throughput: one item per cycle if rsp_tready is high; stages fill bubbles.
// Reset: synchronous, clears every stage valid bit; no item survives reset.
// ----------------------------------------------------------------------------
module segment_rect_intersection_test_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // seg_start_x, seg_start_y, seg_end_x, seg_end_y, rect_left, rect_bottom,
   // rect_width, rect_height, zero pad
   input  logic [srit_pkg::REQ_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // hit, zero pad
   output logic [srit_pkg::RSP_W-1:0] rsp_tdata
);

   logic                s1_valid, s1_ready;
   logic                s2_valid, s2_ready;
   logic                s3_valid, s3_ready;
   srit_pkg::diff_type  s1_data;
   srit_pkg::prod_type  s2_data;
   srit_pkg::edges_type s3_data;
   logic                hit;

   srit_diff u_diff (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   srit_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   srit_comb u_comb (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (s3_valid),
      .out_ready (s3_ready),
      .out_data  (s3_data)
   );

   srit_cmp u_cmp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_ready  (s3_ready),
      .in_data   (s3_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_hit   (hit)
   );

   assign rsp_tdata = {{(srit_pkg::RSP_W-1){1'b0}}, hit};

   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_enter_stage1 : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> s1_valid)
      else $error("accepted request lost at stage 1");

   a_full_when_blocked : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid && s2_valid && s3_valid && rsp_tvalid))
      else $error("request blocked while pipeline has a bubble");

endmodule
